@@ design/alcr_pkg.sv @@
// Package with the shared types, constants and the alignment weight function of the anisotropic life cell rule.
package alcr_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_BORN_SET         = 3'd0;
    localparam logic [2:0] REG_KEEP_SET         = 3'd1;
    localparam logic [2:0] REG_SKEW_MIX         = 3'd2;
    localparam logic [2:0] REG_AXIS_GAIN        = 3'd3;
    localparam logic [2:0] REG_REFRACTORY_TICKS = 3'd4;
    localparam logic [2:0] REG_NOISE_THRESHOLD  = 3'd5;
    localparam logic [2:0] REG_LAYER_ENABLES    = 3'd6;
    localparam logic [2:0] REG_THRESHOLD_BIAS   = 3'd7;

    localparam int LAYER_ANISO = 0;
    localparam int LAYER_BIAS  = 1;
    localparam int LAYER_REFR  = 2;
    localparam int LAYER_NOISE = 3;

    localparam logic [7:0] NEUTRAL_WEIGHT = 8'd128;
    localparam logic [7:0] FULL_WEIGHT    = 8'd255;

    localparam logic [63:0] MIX_GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX_C1     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX_C2     = 64'h94D049BB133111EB;

    typedef struct packed {
        logic [7:0] born_set;
        logic [7:0] keep_set;
        logic [7:0] skew_mix;
        logic [7:0] axis_gain;
        logic [2:0] refractory_ticks;
        logic [7:0] noise_threshold;
        logic [3:0] layer_enables;
        logic [3:0] threshold_bias;
    } cfg_t;

    typedef struct packed {
        logic       cell_alive;
        logic [7:0] neighbour_alive;
        logic [2:0] orientation;
        logic [2:0] refractory_age;
    } cell_in_t;

    typedef struct packed {
        logic       next_alive;
        logic [2:0] next_refractory_age;
    } cell_out_t;

    // Alignment weight of a neighbor direction against the cell orientation.
    function automatic logic [4:0] align_weight(input logic [2:0] orient, input logic [2:0] dir);
        logic [1:0] diff;
        diff = dir[1:0] - orient[1:0];
        case (diff)
            2'd0:    align_weight = 5'd16;
            2'd2:    align_weight = 5'd0;
            default: align_weight = 5'd8;
        endcase
    endfunction

endpackage

@@ design/anisotropic_life_cell_rule.sv @@
// Top level of the anisotropic life cell rule: register file, shared multiplier and sequencer.
// One cell item is evaluated at a time and cell_ready is high only while the sequencer is idle.
// A cell held in its refractory period goes from acceptance straight to the result step. Any
// other cell computes the eight neighbor weights on the shared 32 by 32 multiplier, then a setup
// step, the weighted count division when the weight total is nonzero, the anisotropy blend (two
// products and a step that sums them and divides by 255 with shifts and adds), an evaluation
// step, active noise (two 64-bit splitmix products built from three partial products each) and
// the result step. cell_ready returns in the cycle after the result is loaded. A finished result
// waits in an output register, and the next item is taken while that result is still pending.
module anisotropic_life_cell_rule
    import alcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cell_valid,
    output logic              cell_ready,
    input  cell_in_t          cell_data,
    output logic              result_valid,
    input  logic              result_ready,
    output cell_out_t         result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t        cfg;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] mul_p;

    alcr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    alcr_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    alcr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cell_valid   (cell_valid),
        .cell_ready   (cell_ready),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .mul_a        (mul_a),
        .mul_b        (mul_b),
        .mul_p        (mul_p)
    );

endmodule

@@ design/alcr_regs.sv @@
// Configuration register file with its APB-style access port.
module alcr_regs
    import alcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] index;
    logic       wr_en;

    assign index  = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.born_set         <= 8'd8;
            cfg_reg.keep_set         <= 8'd12;
            cfg_reg.skew_mix         <= 8'd0;
            cfg_reg.axis_gain        <= 8'd128;
            cfg_reg.refractory_ticks <= 3'd0;
            cfg_reg.noise_threshold  <= 8'd0;
            cfg_reg.layer_enables    <= 4'd15;
            cfg_reg.threshold_bias   <= 4'd8;
        end
        else if (wr_en)
        begin
            case (index)
                REG_BORN_SET:         cfg_reg.born_set         <= pwdata[7:0];
                REG_KEEP_SET:         cfg_reg.keep_set         <= pwdata[7:0];
                REG_SKEW_MIX:         cfg_reg.skew_mix         <= pwdata[7:0];
                REG_AXIS_GAIN:        cfg_reg.axis_gain        <= pwdata[7:0];
                REG_REFRACTORY_TICKS: cfg_reg.refractory_ticks <= pwdata[2:0];
                REG_NOISE_THRESHOLD:  cfg_reg.noise_threshold  <= pwdata[7:0];
                REG_LAYER_ENABLES:    cfg_reg.layer_enables    <= pwdata[3:0];
                REG_THRESHOLD_BIAS:   cfg_reg.threshold_bias   <= pwdata[3:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (index)
            REG_BORN_SET:         prdata[7:0] = cfg_reg.born_set;
            REG_KEEP_SET:         prdata[7:0] = cfg_reg.keep_set;
            REG_SKEW_MIX:         prdata[7:0] = cfg_reg.skew_mix;
            REG_AXIS_GAIN:        prdata[7:0] = cfg_reg.axis_gain;
            REG_REFRACTORY_TICKS: prdata[2:0] = cfg_reg.refractory_ticks;
            REG_NOISE_THRESHOLD:  prdata[7:0] = cfg_reg.noise_threshold;
            REG_LAYER_ENABLES:    prdata[3:0] = cfg_reg.layer_enables;
            REG_THRESHOLD_BIAS:   prdata[3:0] = cfg_reg.threshold_bias;
            default:              prdata = '0;
        endcase
    end

endmodule

@@ design/alcr_mul.sv @@
// Shared 32 by 32 bit multiplier with a registered product.
module alcr_mul
    import alcr_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {32'd0, a} * {32'd0, b};
    end

    assign p = p_reg;

endmodule

@@ design/alcr_core.sv @@
// Sequencer and datapath that evaluate one cell over many cycles on the shared multiplier.
module alcr_core
    import alcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        cell_valid,
    output logic        cell_ready,
    input  cell_in_t    cell_data,
    output logic        result_valid,
    input  logic        result_ready,
    output cell_out_t   result,
    output logic [31:0] mul_a,
    output logic [31:0] mul_b,
    input  logic [63:0] mul_p
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DMUL = 4'd1;
    localparam logic [3:0] S_DACC = 4'd2;
    localparam logic [3:0] S_D1S  = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_MA   = 4'd5;
    localparam logic [3:0] S_MB   = 4'd6;
    localparam logic [3:0] S_ADD  = 4'd7;
    localparam logic [3:0] S_EVAL = 4'd8;
    localparam logic [3:0] S_MX0  = 4'd9;
    localparam logic [3:0] S_MX1  = 4'd10;
    localparam logic [3:0] S_MX2  = 4'd11;
    localparam logic [3:0] S_MX3  = 4'd12;
    localparam logic [3:0] S_MXE  = 4'd13;
    localparam logic [3:0] S_FIN  = 4'd14;

    logic [3:0]  state_reg, state_next;
    logic [2:0]  dir_reg, dir_next;
    logic [2:0]  it_reg, it_next;
    logic        alive_reg, alive_next;
    logic [7:0]  nb_reg, nb_next;
    logic [2:0]  orient_reg, orient_next;
    logic [2:0]  age_reg, age_next;
    logic        hold_reg, hold_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [7:0]  wsum_reg, wsum_next;
    logic [7:0]  tot_reg, tot_next;
    logic [7:0]  rem_reg, rem_next;
    logic [7:0]  dq_reg, dq_next;
    logic [7:0]  dvs_reg, dvs_next;
    logic [7:0]  w16_reg, w16_next;
    logic [7:0]  blend_reg, blend_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] x_reg, x_next;
    logic        mph_reg, mph_next;
    logic        fin_alive_reg, fin_alive_next;
    logic [63:0] rng_reg, rng_next;
    logic        out_valid_reg, out_valid_next;
    cell_out_t   out_data_reg, out_data_next;

    logic        aniso_on, bias_on, refr_on, noise_act;
    logic [7:0]  weight;
    logic [4:0]  scale;
    logic [7:0]  raw16;
    logic [8:0]  div_rs;
    logic        div_ge;
    logic [8:0]  div_sub;
    logic [7:0]  div_rem;
    logic [7:0]  div_q;
    logic [15:0] numer;
    logic [16:0] q255;
    logic [8:0]  rounded;
    logic [4:0]  offs;
    logic [2:0]  idx;
    logic        rule_bit;
    logic [63:0] rng_adv;
    logic [63:0] mix_c;
    logic [63:0] mix_z;
    logic [2:0]  fin_age;

    assign aniso_on  = cfg.layer_enables[LAYER_ANISO];
    assign bias_on   = cfg.layer_enables[LAYER_BIAS];
    assign refr_on   = cfg.layer_enables[LAYER_REFR];
    assign noise_act = cfg.layer_enables[LAYER_NOISE] && (cfg.noise_threshold != 8'd0);

    assign cell_ready   = (state_reg == S_IDLE);
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    assign raw16 = {cnt_reg, 4'd0};

    always_comb
    begin
        if (!bias_on)
        begin
            weight = NEUTRAL_WEIGHT;
        end
        else if (dir_reg[0] == 1'b0)
        begin
            weight = cfg.axis_gain;
        end
        else
        begin
            weight = FULL_WEIGHT - cfg.axis_gain;
        end
    end

    assign scale = mul_p[11:7];

    // One restoring division step: one quotient bit per cycle.
    assign div_rs  = {rem_reg, dq_reg[7]};
    assign div_ge  = div_rs >= {1'b0, dvs_reg};
    assign div_sub = div_rs - {1'b0, dvs_reg};
    assign div_rem = div_ge ? div_sub[7:0] : div_rs[7:0];
    assign div_q   = {dq_reg[6:0], div_ge};

    assign numer   = acc_reg[15:0] + mul_p[15:0];
    // Division by 255 as (n + n/256 + 1) / 256, which is exact over the blend range.
    assign q255    = {1'b0, numer} + {9'd0, numer[15:8]} + 17'd1;
    assign rounded = ({1'b0, blend_reg} + 9'd8) >> 4;
    assign offs    = {1'b0, rounded[3:0]} + {1'b0, cfg.threshold_bias};

    always_comb
    begin
        if (offs < 5'd8)
        begin
            idx = 3'd0;
        end
        else if (offs >= 5'd15)
        begin
            idx = 3'd7;
        end
        else
        begin
            idx = offs[2:0];
        end
    end

    assign rule_bit = alive_reg ? cfg.keep_set[idx] : cfg.born_set[idx];
    assign rng_adv  = rng_reg + MIX_GOLDEN;
    assign mix_c    = mph_reg ? MIX_C2 : MIX_C1;
    assign mix_z    = acc_reg ^ (acc_reg >> 31);

    always_comb
    begin
        if (hold_reg)
        begin
            fin_age = age_reg - 3'd1;
        end
        else if (refr_on && alive_reg && !fin_alive_reg)
        begin
            fin_age = cfg.refractory_ticks;
        end
        else
        begin
            fin_age = 3'd0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        it_next        = it_reg;
        alive_next     = alive_reg;
        nb_next        = nb_reg;
        orient_next    = orient_reg;
        age_next       = age_reg;
        hold_next      = hold_reg;
        cnt_next       = cnt_reg;
        wsum_next      = wsum_reg;
        tot_next       = tot_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        dvs_next       = dvs_reg;
        w16_next       = w16_reg;
        blend_next     = blend_reg;
        acc_next       = acc_reg;
        x_next         = x_reg;
        mph_next       = mph_reg;
        fin_alive_next = fin_alive_reg;
        rng_next       = rng_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mul_a          = 32'd0;
        mul_b          = 32'd0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cell_valid)
                begin
                    alive_next  = cell_data.cell_alive;
                    nb_next     = cell_data.neighbour_alive;
                    orient_next = cell_data.orientation;
                    age_next    = cell_data.refractory_age;
                    dir_next    = 3'd0;
                    cnt_next    = 4'd0;
                    wsum_next   = 8'd0;
                    tot_next    = 8'd0;
                    if (refr_on && (cell_data.refractory_age != 3'd0))
                    begin
                        hold_next      = 1'b1;
                        fin_alive_next = 1'b0;
                        state_next     = S_FIN;
                    end
                    else
                    begin
                        hold_next  = 1'b0;
                        state_next = S_DMUL;
                    end
                end
            end
            S_DMUL:
            begin
                mul_a      = {27'd0, align_weight(orient_reg, dir_reg)};
                mul_b      = {24'd0, weight};
                state_next = S_DACC;
            end
            S_DACC:
            begin
                tot_next = tot_reg + {3'd0, scale};
                if (nb_reg[dir_reg])
                begin
                    wsum_next = wsum_reg + {3'd0, scale};
                    cnt_next  = cnt_reg + 4'd1;
                end
                dir_next = dir_reg + 3'd1;
                if (dir_reg == 3'd7)
                begin
                    state_next = S_D1S;
                end
                else
                begin
                    state_next = S_DMUL;
                end
            end
            S_D1S:
            begin
                // The dividend is the weighted sum times 128.
                rem_next  = {1'b0, wsum_reg[7:1]};
                dq_next   = {wsum_reg[0], 7'd0};
                dvs_next  = tot_reg;
                it_next   = 3'd0;
                w16_next  = 8'd0;
                if (tot_reg != 8'd0)
                begin
                    state_next = S_DIV;
                end
                else if (aniso_on)
                begin
                    state_next = S_MA;
                end
                else
                begin
                    blend_next = raw16;
                    state_next = S_EVAL;
                end
            end
            S_DIV:
            begin
                rem_next = div_rem;
                dq_next  = div_q;
                it_next  = it_reg + 3'd1;
                if (it_reg == 3'd7)
                begin
                    if (aniso_on)
                    begin
                        w16_next   = div_q;
                        state_next = S_MA;
                    end
                    else
                    begin
                        blend_next = raw16;
                        state_next = S_EVAL;
                    end
                end
            end
            S_MA:
            begin
                mul_a      = {24'd0, raw16};
                mul_b      = {24'd0, FULL_WEIGHT - cfg.skew_mix};
                state_next = S_MB;
            end
            S_MB:
            begin
                mul_a      = {24'd0, w16_reg};
                mul_b      = {24'd0, cfg.skew_mix};
                acc_next   = mul_p;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                blend_next = q255[15:8];
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                fin_alive_next = rule_bit;
                if (noise_act)
                begin
                    rng_next   = rng_adv;
                    x_next     = rng_adv ^ (rng_adv >> 30);
                    mph_next   = 1'b0;
                    state_next = S_MX0;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MX0:
            begin
                mul_a      = x_reg[31:0];
                mul_b      = mix_c[31:0];
                state_next = S_MX1;
            end
            S_MX1:
            begin
                mul_a      = x_reg[63:32];
                mul_b      = mix_c[31:0];
                acc_next   = mul_p;
                state_next = S_MX2;
            end
            S_MX2:
            begin
                mul_a           = x_reg[31:0];
                mul_b           = mix_c[63:32];
                acc_next[63:32] = acc_reg[63:32] + mul_p[31:0];
                state_next      = S_MX3;
            end
            S_MX3:
            begin
                acc_next[63:32] = acc_reg[63:32] + mul_p[31:0];
                state_next      = S_MXE;
            end
            S_MXE:
            begin
                if (!mph_reg)
                begin
                    x_next     = acc_reg ^ (acc_reg >> 27);
                    mph_next   = 1'b1;
                    state_next = S_MX0;
                end
                else
                begin
                    if (mix_z[15:0] < {8'd0, cfg.noise_threshold})
                    begin
                        fin_alive_next = !fin_alive_reg;
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_valid_next                    = 1'b1;
                    out_data_next.next_alive          = fin_alive_reg;
                    out_data_next.next_refractory_age = fin_age;
                    state_next                        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rng_reg       <= 64'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rng_reg       <= rng_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg       <= dir_next;
        it_reg        <= it_next;
        alive_reg     <= alive_next;
        nb_reg        <= nb_next;
        orient_reg    <= orient_next;
        age_reg       <= age_next;
        hold_reg      <= hold_next;
        cnt_reg       <= cnt_next;
        wsum_reg      <= wsum_next;
        tot_reg       <= tot_next;
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        dvs_reg       <= dvs_next;
        w16_reg       <= w16_next;
        blend_reg     <= blend_next;
        acc_reg       <= acc_next;
        x_reg         <= x_next;
        mph_reg       <= mph_next;
        fin_alive_reg <= fin_alive_next;
        out_data_reg  <= out_data_next;
    end

    // The generator only advances when a cell is evaluated with noise active.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_EVAL) |=> $stable(rng_reg))
        else $error("noise generator changed outside evaluation");

    // A cell held in its refractory period goes straight to the result stage, dead.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid && cell_ready && refr_on && (cell_data.refractory_age != 3'd0))
        |=> (state_reg == S_FIN) && !fin_alive_reg && hold_reg)
        else $error("refractory hold not taken");

    // The blended count never exceeds eight sixteenths units times sixteen.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EVAL) |-> (blend_reg <= 8'd128))
        else $error("blended count out of range");

    // A finished result waits while the output register is still full.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && out_valid_reg && !result_ready |=> (state_reg == S_FIN))
        else $error("result overwrote a pending item");

endmodule

@@ test/anisotropic_life_cell_rule_tb.sv @@
// Self-checking testbench for the anisotropic life cell rule, with a scoreboard class.
module anisotropic_life_cell_rule_tb;
    import alcr_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 60;

    class cell_scoreboard;
        localparam logic [63:0] SPLIT_GOLDEN = 64'h9E3779B97F4A7C15;
        localparam logic [63:0] SPLIT_MUL1   = 64'hBF58476D1CE4E5B9;
        localparam logic [63:0] SPLIT_MUL2   = 64'h94D049BB133111EB;

        logic [7:0]  born_set;
        logic [7:0]  keep_set;
        logic [7:0]  skew_mix;
        logic [7:0]  axis_gain;
        logic [2:0]  refractory_ticks;
        logic [7:0]  noise_threshold;
        logic [3:0]  layer_enables;
        logic [3:0]  threshold_bias;
        logic [63:0] noise_state;
        cell_out_t   expected_q[$];
        int          errors;

        function new();
            born_set         = 8'd8;
            keep_set         = 8'd12;
            skew_mix         = 8'd0;
            axis_gain        = 8'd128;
            refractory_ticks = 3'd0;
            noise_threshold  = 8'd0;
            layer_enables    = 4'd15;
            threshold_bias   = 4'd8;
            noise_state      = 64'd0;
            errors           = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_BORN_SET:         born_set         = value[7:0];
                REG_KEEP_SET:         keep_set         = value[7:0];
                REG_SKEW_MIX:         skew_mix         = value[7:0];
                REG_AXIS_GAIN:        axis_gain        = value[7:0];
                REG_REFRACTORY_TICKS: refractory_ticks = value[2:0];
                REG_NOISE_THRESHOLD:  noise_threshold  = value[7:0];
                REG_LAYER_ENABLES:    layer_enables    = value[3:0];
                REG_THRESHOLD_BIAS:   threshold_bias   = value[3:0];
                default: ;
            endcase
        endfunction

        function cell_out_t next_cell_state(cell_in_t c);
            cell_out_t   r;
            int unsigned raw16;
            int unsigned weighted;
            int unsigned total;
            int unsigned scale;
            int unsigned w;
            int unsigned weighted16;
            int unsigned blended16;
            int          count;
            logic [2:0]  idx;
            logic [1:0]  diff;
            logic        next;
            logic [63:0] z;
            raw16 = 0;
            weighted = 0;
            total = 0;
            if (layer_enables[LAYER_REFR] && c.refractory_age != 3'd0)
            begin
                r.next_alive = 1'b0;
                r.next_refractory_age = c.refractory_age - 3'd1;
                return r;
            end
            for (int d = 0; d < 8; d++)
            begin
                diff = 2'(d) - c.orientation[1:0];
                scale = (diff == 2'd0) ? 16 : ((diff == 2'd2) ? 0 : 8);
                if (layer_enables[LAYER_BIAS])
                begin
                    w = (d % 2 == 0) ? axis_gain : 255 - axis_gain;
                    scale = scale * w / 128;
                end
                raw16 += c.neighbour_alive[d] ? 16 : 0;
                weighted += c.neighbour_alive[d] ? scale : 0;
                total += scale;
            end
            weighted16 = (total > 0) ? weighted * 128 / total : 0;
            if (layer_enables[LAYER_ANISO])
                blended16 = (raw16 * (255 - skew_mix) + weighted16 * skew_mix) / 255;
            else
                blended16 = raw16;
            count = int'((blended16 + 8) / 16) + int'(threshold_bias) - 8;
            if (count < 0)
                idx = 3'd0;
            else if (count >= 7)
                idx = 3'd7;
            else
                idx = 3'(count);
            next = c.cell_alive ? keep_set[idx] : born_set[idx];
            if (layer_enables[LAYER_NOISE] && noise_threshold != 8'd0)
            begin
                noise_state = noise_state + SPLIT_GOLDEN;
                z = noise_state;
                z = (z ^ (z >> 30)) * SPLIT_MUL1;
                z = (z ^ (z >> 27)) * SPLIT_MUL2;
                z = z ^ (z >> 31);
                if (z[15:0] < noise_threshold)
                    next = ~next;
            end
            r.next_alive = next;
            r.next_refractory_age = (layer_enables[LAYER_REFR] && c.cell_alive && !next)
                                    ? refractory_ticks : 3'd0;
            return r;
        endfunction

        function void note_cell(cell_in_t c);
            expected_q.push_back(next_cell_state(c));
        endfunction

        function void check_result(cell_out_t got);
            cell_out_t exp_r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result item, expected none, actual %b", $time, got);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.next_alive !== exp_r.next_alive)
            begin
                $display("%0t: next_alive expected %0d actual %0d",
                         $time, exp_r.next_alive, got.next_alive);
                errors++;
            end
            if (got.next_refractory_age !== exp_r.next_refractory_age)
            begin
                $display("%0t: next_refractory_age expected %0d actual %0d",
                         $time, exp_r.next_refractory_age, got.next_refractory_age);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              cell_valid;
    logic              cell_ready;
    cell_in_t          cell_data;
    logic              result_valid;
    logic              result_ready;
    cell_out_t         result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    cell_scoreboard board;
    int             send_idle;
    int             recv_idle;
    int             cells_sent;
    int             stall_cycles;

    anisotropic_life_cell_rule dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_valid   (cell_valid),
        .cell_ready   (cell_ready),
        .cell_data    (cell_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
                board.check_result(result);
            result_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cell_valid && cell_ready) || (result_valid && result_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        board.set_reg(idx, data);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [31:0] birth, input logic [31:0] survive,
                                input logic [31:0] strength, input logic [31:0] bias,
                                input logic [31:0] ticks, input logic [31:0] noise,
                                input logic [31:0] layers, input logic [31:0] offset);
        write_reg(REG_BORN_SET, birth);
        write_reg(REG_KEEP_SET, survive);
        write_reg(REG_SKEW_MIX, strength);
        write_reg(REG_AXIS_GAIN, bias);
        write_reg(REG_REFRACTORY_TICKS, ticks);
        write_reg(REG_NOISE_THRESHOLD, noise);
        write_reg(REG_LAYER_ENABLES, layers);
        write_reg(REG_THRESHOLD_BIAS, offset);
    endtask

    task automatic send_cell(input cell_in_t c);
        if (cells_sent < 270)
        begin
            send_idle = 23;
            recv_idle = 48;
        end
        else if (cells_sent < 540)
        begin
            send_idle = 48;
            recv_idle = 23;
        end
        else
        begin
            send_idle = 0;
            recv_idle = 0;
        end
        while ($urandom_range(99) < send_idle)
        begin
            cell_valid <= 1'b0;
            @(posedge clk);
        end
        cell_valid <= 1'b1;
        cell_data <= c;
        do @(posedge clk); while (!cell_ready);
        board.note_cell(c);
        cells_sent++;
    endtask

    task automatic send_fields(input logic alive, input logic [7:0] nb,
                               input logic [2:0] orient, input logic [2:0] age);
        cell_in_t c;
        c.cell_alive = alive;
        c.neighbour_alive = nb;
        c.orientation = orient;
        c.refractory_age = age;
        send_cell(c);
    endtask

    task automatic finish_phase();
        cell_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic random_config(input int kind);
        case (kind)
            0: apply_config('1, '1, '1, '1, '1, '1, '1, '1);
            1: apply_config('0, '0, '0, '0, '0, '0, '0, '0);
            default: apply_config($urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom_range(1) ? $urandom : 32'hFF, $urandom,
                                  $urandom_range(1) ? $urandom : $urandom_range(10, 6));
        endcase
    endtask

    task automatic run_random(input int count);
        cell_in_t c;
        logic [7:0] nb;
        repeat (count)
        begin
            case ($urandom_range(2))
                0: nb = 8'($urandom);
                1: nb = 8'($urandom & $urandom);
                default: nb = 8'($urandom | $urandom);
            endcase
            c.cell_alive = 1'($urandom_range(1));
            c.neighbour_alive = nb;
            c.orientation = 3'($urandom_range(7));
            c.refractory_age = ($urandom_range(99) < 70) ? 3'd0 : 3'($urandom_range(7));
            send_cell(c);
        end
    endtask

    initial
    begin
        board = new();
        send_idle = 23;
        recv_idle = 48;
        cells_sent = 0;
        stall_cycles <= 0;
        rst_n <= 1'b0;
        cell_valid <= 1'b0;
        cell_data <= '0;
        result_ready <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: birth at three, survival at two or three, no ticks.
        send_fields(1'b0, 8'h00, 3'd0, 3'd0);
        send_fields(1'b0, 8'h07, 3'd1, 3'd0);
        send_fields(1'b1, 8'h03, 3'd2, 3'd0);
        send_fields(1'b1, 8'hFF, 3'd7, 3'd0);
        send_fields(1'b1, 8'h01, 3'd3, 3'd0);
        send_fields(1'b1, 8'h00, 3'd5, 3'd7);
        send_fields(1'b0, 8'hFF, 3'd6, 3'd1);
        finish_phase();

        apply_config(32'hFF, 32'h00, 32'd255, 32'd255, 32'd7, 32'd255, 32'd15, 32'd15);
        send_fields(1'b1, 8'h55, 3'd0, 3'd0);
        send_fields(1'b1, 8'hAA, 3'd1, 3'd0);
        send_fields(1'b0, 8'h00, 3'd3, 3'd0);
        send_fields(1'b1, 8'hFF, 3'd4, 3'd0);
        send_fields(1'b1, 8'h0F, 3'd2, 3'd3);
        send_fields(1'b0, 8'hF0, 3'd5, 3'd0);
        send_fields(1'b1, 8'h81, 3'd6, 3'd0);
        send_fields(1'b1, 8'h3C, 3'd7, 3'd0);
        finish_phase();

        apply_config(32'h00, 32'hFF, 32'd128, 32'd0, 32'd5, 32'd0, 32'd6, 32'd0);
        send_fields(1'b1, 8'h00, 3'd0, 3'd0);
        send_fields(1'b0, 8'hFF, 3'd1, 3'd5);
        send_fields(1'b1, 8'hFF, 3'd2, 3'd0);
        send_fields(1'b0, 8'h24, 3'd3, 3'd0);
        finish_phase();

        for (int p = 0; p < 8; p++)
        begin
            random_config(p);
            run_random(100);
            finish_phase();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ anisotropic_life_cell_rule.f @@
design/alcr_pkg.sv
design/alcr_regs.sv
design/alcr_mul.sv
design/alcr_core.sv
design/anisotropic_life_cell_rule.sv
test/anisotropic_life_cell_rule_tb.sv
